// File: hw/rtl/fima_pkg.sv
// Shared types, constants and codes for the frame interval moving average unit.
// No dependencies; every other file imports this package.
package fima_pkg;

    localparam int WINDOW_MAX     = 64;
    localparam int DEFAULT_WINDOW = 8;

    localparam int VAL_W      = 32;
    localparam int TS_W       = 48;
    localparam int REQ_W      = 2;
    localparam int WS_FIELD_W = 7;
    localparam int IDX_W      = $clog2(WINDOW_MAX);
    localparam int WS_W       = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W      = VAL_W + IDX_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CNT_W      = $clog2(SUM_W);

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UP_THRESHOLD   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CLAMP_LO       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CLAMP_HI       = 3'd5;

    localparam logic [REQ_W-1:0] REQ_COMMIT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TICK   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TOUCH  = 2'd2;

    localparam logic [VAL_W-1:0] RST_UP   = 32'd10000;
    localparam logic [VAL_W-1:0] RST_DOWN = 32'd3000000;
    localparam logic [VAL_W-1:0] RST_MIN  = 32'd16667;
    localparam logic [VAL_W-1:0] RST_MAX  = 32'd4000000;
    localparam logic [WS_W-1:0]  RST_WS   = WS_W'(DEFAULT_WINDOW);
    localparam logic [SUM_W-1:0] RST_SUM  = SUM_W'(16667 * DEFAULT_WINDOW);

    typedef struct packed {
        logic             enable;
        logic [WS_W-1:0]  window_size;
        logic [VAL_W-1:0] up_threshold;
        logic [VAL_W-1:0] down_threshold;
        logic [VAL_W-1:0] clamp_lo;
        logic [VAL_W-1:0] clamp_hi;
    } fima_cfg_t;

    typedef struct packed {
        logic            fill;
        logic [WS_W-1:0] size;
    } fima_fill_t;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CLAMP = 6'b000010,
        ST_ACCUM = 6'b000100,
        ST_START = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_DONE  = 6'b100000
    } fima_state_t;

endpackage

// File: hw/rtl/fima_cfg_regs.sv
// Configuration register file with window-size saturation and refill request.
// Depends on fima_pkg.
module fima_cfg_regs import fima_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VAL_W-1:0]     cfg_data,
    output fima_cfg_t            cfg,
    output fima_fill_t           fill
);

    fima_cfg_t cfg_reg, cfg_next;
    logic [WS_FIELD_W-1:0] ws_raw;
    logic [WS_W-1:0]       ws_sat;

    assign ws_raw = cfg_data[WS_FIELD_W-1:0];
    assign ws_sat = (int'(ws_raw) > WINDOW_MAX) ? WS_W'(WINDOW_MAX) : WS_W'(ws_raw);

    always_comb begin
        cfg_next  = cfg_reg;
        fill.fill = 1'b0;
        fill.size = ws_sat;
        if (cfg_valid) begin
            case (cfg_index)
                REG_ENABLE:         cfg_next.enable         = cfg_data[0];
                REG_WINDOW_SIZE: begin
                    if (ws_raw != '0 && ws_sat != cfg_reg.window_size) begin
                        cfg_next.window_size = ws_sat;
                        fill.fill            = 1'b1;
                    end
                end
                REG_UP_THRESHOLD:   cfg_next.up_threshold   = cfg_data;
                REG_DOWN_THRESHOLD: cfg_next.down_threshold = cfg_data;
                REG_CLAMP_LO:       cfg_next.clamp_lo       = cfg_data;
                REG_CLAMP_HI:       cfg_next.clamp_hi       = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable         <= 1'b0;
            cfg_reg.window_size    <= RST_WS;
            cfg_reg.up_threshold   <= RST_UP;
            cfg_reg.down_threshold <= RST_DOWN;
            cfg_reg.clamp_lo       <= RST_MIN;
            cfg_reg.clamp_hi       <= RST_MAX;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hw/rtl/fima_window_store.sv
// Interval window memory with per-entry valid bits; invalid entries read the fill value.
// Depends on fima_pkg.
module fima_window_store import fima_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             clear,
    input  logic [VAL_W-1:0] clear_value,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic [VAL_W-1:0] wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output logic [VAL_W-1:0] rd_data
);

    logic [VAL_W-1:0]      mem [WINDOW_MAX];
    logic [WINDOW_MAX-1:0] valid_reg;
    logic [VAL_W-1:0]      fill_value_reg;
    logic [VAL_W-1:0]      mem_q_reg;
    logic                  valid_q_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            valid_q_reg    <= 1'b0;
            fill_value_reg <= RST_MIN;
        end else begin
            if (clear) begin
                valid_reg      <= '0;
                fill_value_reg <= clear_value;
            end else if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                valid_q_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = valid_q_reg ? mem_q_reg : fill_value_reg;

endmodule

// File: hw/rtl/fima_serial_div.sv
// Restoring bit-serial divider: running sum by window size, one quotient bit per cycle.
// Depends on fima_pkg.
module fima_serial_div import fima_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    input  logic [WS_W-1:0]  divisor,
    output logic             done,
    output logic [VAL_W-1:0] quotient
);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] count_reg;
    logic [SUM_W-1:0] work_reg;
    logic [WS_W-1:0]  rem_reg;
    logic [WS_W-1:0]  div_reg;
    logic [WS_W:0]    shifted;
    logic             fits;

    assign shifted = {rem_reg, work_reg[SUM_W-1]};
    assign fits    = shifted >= {1'b0, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end else if (busy_reg) begin
                if (count_reg == CNT_W'(SUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            work_reg <= dividend;
            rem_reg  <= '0;
            div_reg  <= divisor;
        end else if (busy_reg) begin
            work_reg <= {work_reg[SUM_W-2:0], fits};
            rem_reg  <= fits ? WS_W'(shifted - {1'b0, div_reg}) : shifted[WS_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = work_reg[VAL_W-1:0];

endmodule

// File: hw/rtl/frame_interval_moving_average_unit.sv
// Top level of the frame interval moving average unit: event sequencer and result register.
// Depends on fima_pkg, fima_cfg_regs, fima_window_store and fima_serial_div.
//
//  channel  direction  tdata / data                               tuser / index
//  s_       in         [47:0] timestamp_us                        [1:0] req_type
//  m_       out        [31:0] clamped_interval, [63:32] average,  [0] status
//                      [64] notify, [71:65] zero
//  cfg_     in         [31:0] register value                      cfg_index [2:0]
//
// An enabled commit or tick goes from accept to result through clamp, window update,
// divider start, 38 divider steps, taking the quotient and loading the result. Rejected,
// touch and unused events go from accept straight to the result. s_tready is high only in
// idle; a result waiting on m_tready does not block the next accept but holds the one
// after it. cfg_ready is always high. Reset is synchronous and needs no clearing pass:
// valid bits cover the window.
module frame_interval_moving_average_unit import fima_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [47:0]          s_tdata,   // timestamp_us
    input  logic [1:0]           s_tuser,   // req_type
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [71:0]          m_tdata,   // clamped_interval, average_interval, notify
    output logic [0:0]           m_tuser,   // status
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VAL_W-1:0]     cfg_data
);

    fima_cfg_t   cfg;
    fima_fill_t  fill;
    fima_state_t state_reg, state_next;

    logic [TS_W-1:0]  prev_time_reg;
    logic [TS_W-1:0]  raw_reg;
    logic [REQ_W-1:0] req_reg;
    logic [VAL_W-1:0] clamped_reg;
    logic [VAL_W-1:0] avg_reg;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [IDX_W-1:0] widx_reg;
    logic             status_reg;
    logic             notify_reg;

    logic                  m_valid_reg;
    logic [VAL_W-1:0]      out_clamped_reg;
    logic [VAL_W-1:0]      out_avg_reg;
    logic                  out_status_reg;
    logic                  out_notify_reg;

    logic                  s_accept;
    logic [VAL_W-1:0]      old_val;
    logic                  div_done;
    logic [VAL_W-1:0]      quotient;
    logic [VAL_W+WS_W-1:0] fill_product;
    logic [IDX_W:0]        widx_inc;
    logic [VAL_W-1:0]      clamp_val;

    fima_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .fill      (fill)
    );

    fima_window_store u_store (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .clear       (fill.fill),
        .clear_value (cfg.clamp_lo),
        .wr_en       (state_reg == ST_ACCUM),
        .wr_addr     (widx_reg),
        .wr_data     (clamped_reg),
        .rd_en       (s_accept),
        .rd_addr     (widx_reg),
        .rd_data     (old_val)
    );

    fima_serial_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == ST_START),
        .dividend (sum_reg),
        .divisor  (cfg.window_size),
        .done     (div_done),
        .quotient (quotient)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;

    assign fill_product = cfg.clamp_lo * fill.size;
    assign sum_next     = sum_reg - SUM_W'(old_val) + SUM_W'(clamped_reg);
    assign widx_inc     = {1'b0, widx_reg} + (IDX_W+1)'(1);

    always_comb begin
        if (raw_reg < TS_W'(cfg.clamp_lo)) begin
            clamp_val = cfg.clamp_lo;
        end else if (raw_reg > TS_W'(cfg.clamp_hi)) begin
            clamp_val = cfg.clamp_hi;
        end else begin
            clamp_val = raw_reg[VAL_W-1:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (cfg.enable && (s_tuser == REQ_COMMIT || s_tuser == REQ_TICK)) begin
                        state_next = ST_CLAMP;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_CLAMP: state_next = ST_ACCUM;
            ST_ACCUM: state_next = ST_START;
            ST_START: state_next = ST_DIV;
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            prev_time_reg <= '0;
            sum_reg       <= RST_SUM;
            avg_reg       <= RST_MIN;
            widx_reg      <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_DONE && (!m_valid_reg || m_tready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (fill.fill) begin
                sum_reg  <= fill_product[SUM_W-1:0];
                avg_reg  <= cfg.clamp_lo;
                widx_reg <= '0;
            end else begin
                case (state_reg)
                    ST_IDLE: begin
                        if (s_accept && cfg.enable) begin
                            if (s_tuser == REQ_COMMIT || s_tuser == REQ_TICK) begin
                                prev_time_reg <= s_tdata;
                            end else if (s_tuser == REQ_TOUCH) begin
                                avg_reg <= cfg.clamp_lo;
                            end
                        end
                    end
                    ST_ACCUM: begin
                        sum_reg  <= sum_next;
                        widx_reg <= (widx_inc >= cfg.window_size) ?
                                    '0 : widx_inc[IDX_W-1:0];
                    end
                    ST_DIV: begin
                        if (div_done) begin
                            avg_reg <= quotient;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    req_reg     <= s_tuser;
                    raw_reg     <= s_tdata - prev_time_reg;
                    clamped_reg <= '0;
                    status_reg  <= !cfg.enable;
                    notify_reg  <= cfg.enable && (s_tuser == REQ_TOUCH);
                end
            end
            ST_CLAMP: begin
                clamped_reg <= clamp_val;
                notify_reg  <= (cfg.down_threshold < clamp_val) ||
                               (req_reg == REQ_COMMIT && cfg.up_threshold > clamp_val);
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    out_clamped_reg <= clamped_reg;
                    out_avg_reg     <= avg_reg;
                    out_status_reg  <= status_reg;
                    out_notify_reg  <= notify_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, out_notify_reg, out_avg_reg, out_clamped_reg};
    assign m_tuser  = out_status_reg;

endmodule

// File: tb/frame_interval_moving_average_unit_tb.sv
// Testbench for frame_interval_moving_average_unit: directed and random event streams with
// random stalls on both channels, checked against a windowed-average predictor class.
// Depends on fima_pkg and the unit's RTL only.
module frame_interval_moving_average_unit_tb;
    import fima_pkg::*;

    localparam int         STALL_LIMIT     = 3000;
    localparam int         RANDOM_PHASES   = 10;
    localparam int         ITEMS_PER_PHASE = 190;
    localparam logic [1:0] REQ_UNUSED      = 2'd3;

    typedef struct packed {
        logic        status;
        logic [31:0] clamped;
        logic [31:0] average;
        logic        notify;
    } avg_result_t;

    class interval_avg_tracker;
        logic        en;
        logic [6:0]  win_size;
        logic [31:0] up_thr;
        logic [31:0] down_thr;
        logic [31:0] min_ivl;
        logic [31:0] max_ivl;
        logic [47:0] last_time;
        logic [31:0] ivl_ring [WINDOW_MAX];
        logic [37:0] ring_sum;
        logic [31:0] ring_avg;
        int          ring_pos;
        avg_result_t expected_results [$];
        int          mismatches;

        function new();
            en         = 1'b0;
            win_size   = 7'(DEFAULT_WINDOW);
            up_thr     = RST_UP;
            down_thr   = RST_DOWN;
            min_ivl    = RST_MIN;
            max_ivl    = RST_MAX;
            last_time  = '0;
            mismatches = 0;
            refill();
        endfunction

        function void refill();
            for (int i = 0; i < WINDOW_MAX; i++) begin
                ivl_ring[i] = min_ivl;
            end
            ring_sum = 38'(min_ivl) * 38'(win_size);
            ring_avg = min_ivl;
            ring_pos = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
            logic [6:0] w;
            w = data[6:0];
            case (idx)
                REG_ENABLE: en = data[0];
                REG_WINDOW_SIZE: begin
                    if (w != 0) begin
                        if (w > WINDOW_MAX) w = 7'(WINDOW_MAX);
                        if (w != win_size) begin
                            win_size = w;
                            refill();
                        end
                    end
                end
                REG_UP_THRESHOLD:   up_thr   = data;
                REG_DOWN_THRESHOLD: down_thr = data;
                REG_CLAMP_LO:       min_ivl  = data;
                REG_CLAMP_HI:       max_ivl  = data;
                default: ;
            endcase
        endfunction

        function void note_event(logic [1:0] req, logic [47:0] ts);
            avg_result_t r;
            logic [47:0] raw;
            logic [31:0] old;
            r = '0;
            if (!en) begin
                r.status = 1'b1;
            end else if (req == REQ_COMMIT || req == REQ_TICK) begin
                raw       = ts - last_time;
                last_time = ts;
                if (raw < {16'd0, min_ivl}) r.clamped = min_ivl;
                else if (raw > {16'd0, max_ivl}) r.clamped = max_ivl;
                else r.clamped = raw[31:0];
                old      = ivl_ring[ring_pos];
                ring_sum = ring_sum - {6'd0, old} + {6'd0, r.clamped};
                ring_avg = 32'(ring_sum / {31'd0, win_size});
                ivl_ring[ring_pos] = r.clamped;
                ring_pos = (ring_pos + 1 >= win_size) ? 0 : ring_pos + 1;
                r.notify = (down_thr < r.clamped) || (req == REQ_COMMIT && up_thr > r.clamped);
            end else if (req == REQ_TOUCH) begin
                ring_avg = min_ivl;
                r.notify = 1'b1;
            end
            r.average = ring_avg;
            expected_results.push_back(r);
        endfunction

        function void check_result(logic [71:0] data, logic status);
            avg_result_t want;
            avg_result_t got;
            got.status  = status;
            got.clamped = data[31:0];
            got.average = data[63:32];
            got.notify  = data[64];
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d clamped %0d average %0d notify %0d",
                             got.status, got.clamped, got.average, got.notify);
            end else begin
                want = expected_results.pop_front();
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result mismatch (expected/actual): status %0d/%0d ",
                                  "clamped %0d/%0d average %0d/%0d notify %0d/%0d"},
                                 want.status, got.status, want.clamped, got.clamped,
                                 want.average, got.average, want.notify, got.notify);
                end
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [47:0]          s_tdata;
    logic [1:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [71:0]          m_tdata;
    logic [0:0]           m_tuser;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [VAL_W-1:0]     cfg_data;

    interval_avg_tracker sb = new();
    logic [47:0]         now_us;
    logic                no_idle;
    int                  idle_cycles;

    frame_interval_moving_average_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    always @(negedge aclk) begin
        if (no_idle) m_tready = 1'b1;
        else m_tready = ($urandom_range(0, 99) >= 21);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser[0]);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_event(input logic [1:0] req, input logic [47:0] ts);
        while (!no_idle && $urandom_range(0, 99) < 21) @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser  = req;
        s_tdata  = ts;
        do @(posedge aclk); while (!s_tready);
        sb.note_event(req, ts);
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic step(input logic [1:0] req, input logic [47:0] gap);
        now_us = now_us + gap;
        send_event(req, now_us);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, value);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic drain();
        while (sb.expected_results.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic random_setup();
        logic [31:0] lo;
        logic [31:0] hi;
        case ($urandom_range(0, 9))
            0:       lo = '0;
            1:       lo = $urandom;
            default: lo = $urandom_range(1000, 40000);
        endcase
        case ($urandom_range(0, 9))
            0:       hi = '1;
            1:       hi = $urandom;
            default: hi = lo + $urandom_range(0, 5000000);
        endcase
        cfg_write(REG_CLAMP_LO, lo);
        cfg_write(REG_CLAMP_HI, hi);
        case ($urandom_range(0, 9))
            0:       cfg_write(REG_UP_THRESHOLD, '1);
            1:       cfg_write(REG_UP_THRESHOLD, '0);
            2:       cfg_write(REG_UP_THRESHOLD, $urandom);
            default: cfg_write(REG_UP_THRESHOLD, $urandom_range(0, 60000));
        endcase
        case ($urandom_range(0, 9))
            0:       cfg_write(REG_DOWN_THRESHOLD, '0);
            1:       cfg_write(REG_DOWN_THRESHOLD, '1);
            2:       cfg_write(REG_DOWN_THRESHOLD, $urandom);
            default: cfg_write(REG_DOWN_THRESHOLD, $urandom_range(20000, 6000000));
        endcase
        case ($urandom_range(0, 19))
            0:          cfg_write(REG_WINDOW_SIZE, '0);
            1:          cfg_write(REG_WINDOW_SIZE, $urandom_range(65, 127));
            2, 3, 4:    cfg_write(REG_WINDOW_SIZE, WINDOW_MAX);
            5, 6:       cfg_write(REG_WINDOW_SIZE, $urandom_range(1, 64));
            default:    cfg_write(REG_WINDOW_SIZE, $urandom_range(1, 16));
        endcase
        cfg_write(REG_ENABLE, 32'($urandom_range(0, 7) != 0));
    endtask

    task automatic random_event();
        int          pick;
        logic [47:0] gap;
        logic [1:0]  req;
        pick = $urandom_range(0, 99);
        if (pick < 60) req = REQ_COMMIT;
        else if (pick < 84) req = REQ_TICK;
        else if (pick < 97) req = REQ_TOUCH;
        else req = REQ_UNUSED;
        case ($urandom_range(0, 6))
            0:       gap = 48'($urandom_range(0, 20000));
            1:       gap = {16'd0, sb.up_thr} + 48'($urandom_range(0, 2)) - 48'd1;
            2:       gap = {16'd0, sb.down_thr} + 48'($urandom_range(0, 2)) - 48'd1;
            3:       gap = {16'd0, sb.min_ivl} + 48'($urandom_range(0, 2)) - 48'd1;
            4:       gap = {16'd0, sb.max_ivl} + 48'($urandom_range(0, 2)) - 48'd1;
            5:       gap = 48'($urandom_range(10000, 100000));
            default: gap = {16'($urandom), 32'($urandom)};
        endcase
        if ($urandom_range(0, 99) < 8) begin
            now_us = {16'($urandom), 32'($urandom)};
            req    = 2'($urandom_range(0, 3));
            send_event(req, now_us);
        end else begin
            step(req, gap);
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        m_tready    = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        no_idle     = 1'b0;
        now_us      = '0;
        idle_cycles = 0;
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;

        // rejected while disabled
        send_event(REQ_COMMIT, 48'd5);
        send_event(REQ_TICK, 48'd40000);
        send_event(REQ_TOUCH, 48'd70000);
        send_event(REQ_UNUSED, 48'd90000);
        drain();
        cfg_write(REG_ENABLE, 32'd1);

        now_us = '0;
        send_event(REQ_COMMIT, now_us);
        step(REQ_COMMIT, 48'd5000);
        step(REQ_COMMIT, 48'd20000);
        step(REQ_TICK, 48'd3000001);
        step(REQ_COMMIT, 48'd5000000);
        send_event(REQ_TOUCH, '1);
        send_event(REQ_UNUSED, 48'h1234_5678_9abc);
        now_us = '1;
        send_event(REQ_COMMIT, now_us);
        step(REQ_COMMIT, 48'd11);
        drain();

        // open thresholds and clamps, ignored zero size, single-entry window
        cfg_write(REG_UP_THRESHOLD, '1);
        cfg_write(REG_DOWN_THRESHOLD, '0);
        cfg_write(REG_CLAMP_LO, '0);
        cfg_write(REG_CLAMP_HI, '1);
        cfg_write(REG_WINDOW_SIZE, 32'd0);
        cfg_write(REG_WINDOW_SIZE, 32'd1);
        step(REQ_COMMIT, 48'd7);
        step(REQ_TICK, 48'h1_0000_0004);
        drain();

        // min above max, oversized window saturates, rewrite of current size
        cfg_write(REG_CLAMP_LO, 32'd50000);
        cfg_write(REG_CLAMP_HI, 32'd100);
        cfg_write(REG_WINDOW_SIZE, 32'd100);
        cfg_write(REG_WINDOW_SIZE, WINDOW_MAX);
        step(REQ_COMMIT, 48'd1000);
        step(REQ_COMMIT, 48'd70000);
        step(REQ_TICK, 48'd50000);
        drain();

        cfg_write(REG_WINDOW_SIZE, 32'd127);
        cfg_write(REG_UP_THRESHOLD, 32'd20000);
        cfg_write(REG_DOWN_THRESHOLD, 32'd3000000);
        cfg_write(REG_CLAMP_LO, 32'd16667);
        cfg_write(REG_CLAMP_HI, 32'd4000000);
        cfg_write(REG_WINDOW_SIZE, 32'd2);
        step(REQ_COMMIT, 48'd18000);
        step(REQ_TICK, 48'd18000);
        step(REQ_COMMIT, 48'd9999);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            drain();
            random_setup();
            no_idle = (p == 3);
            repeat (ITEMS_PER_PHASE) random_event();
        end
        no_idle = 1'b0;

        drain();
        repeat (60) @(negedge aclk);
        if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
